[hw/rtl/bwt_pkg.sv]
package bwt_pkg;

  localparam int unsigned MaxBlocks  = 64;
  localparam int unsigned WeightBits = 32;
  localparam int unsigned IdxBits    = $clog2(MaxBlocks);
  localparam int unsigned NumBlkBits = 7;
  localparam int unsigned ActBits    = 3;
  localparam int unsigned StatBits   = 2;

  localparam logic [NumBlkBits-1:0] NumBlocksReset = NumBlkBits'(MaxBlocks);

  typedef enum logic [ActBits-1:0] {
    ActClear      = 3'd0,
    ActAccumulate = 3'd1,
    ActLoadTotal  = 3'd2,
    ActSetTotal   = 3'd3,
    ActGetTotal   = 3'd4
  } action_e;

  typedef enum logic [StatBits-1:0] {
    StatOk       = 2'd0,
    StatRange    = 2'd1,
    StatOverflow = 2'd2,
    StatStale    = 2'd3
  } status_e;

  typedef enum logic {
    StIdle = 1'b0,
    StExec = 1'b1
  } state_e;

endpackage

[hw/rtl/bwt_ram.sv]
module bwt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/block_weight_table.sv]
// Channel  | Handshake               | Payload
// input    | in_valid_i / in_ready_o | action_i, block_index_i, weight_i
// output   | out_valid_o/ out_ready_i| total_out_o, status_o
// config   | cfg_we_i (no wait)      | cfg_wdata_i (num_blocks)
//
// Each item is handled in order: accept and table read, then update and result load.
// The registered read of the two table RAMs sets this split; one item a time.
// An item is accepted while an earlier result still waits in the output register.
// Reset clears per-entry valid bits at once; no clearing pass is needed.
// When the output register is full, the update stage holds until it drains.
module block_weight_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bwt_pkg::ActBits-1:0]   action_i,
  input  logic [bwt_pkg::IdxBits-1:0]   block_index_i,
  input  logic [bwt_pkg::WeightBits-1:0] weight_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bwt_pkg::WeightBits-1:0] total_out_o,
  output logic [bwt_pkg::StatBits-1:0]  status_o,
  input  logic                          cfg_we_i,
  input  logic [bwt_pkg::NumBlkBits-1:0] cfg_wdata_i
);

  localparam int unsigned W = bwt_pkg::WeightBits;

  bwt_pkg::state_e state_q, state_d;

  logic [bwt_pkg::NumBlkBits-1:0] num_blocks_q;
  logic [bwt_pkg::ActBits-1:0]    act_q;
  logic [bwt_pkg::IdxBits-1:0]    blk_q;
  logic [W-1:0]                   wgt_q;

  logic [bwt_pkg::MaxBlocks-1:0] lvld_q, lvld_d;
  logic [bwt_pkg::MaxBlocks-1:0] gvld_q, gvld_d;

  logic                          out_valid_q, out_valid_d;
  logic [W-1:0]                  total_q, total_d;
  logic [bwt_pkg::StatBits-1:0]  status_q, status_d;

  logic         in_acc, go;
  logic [W-1:0] l_rdata, g_rdata, loc, prev;
  logic         l_we, g_we, clr;
  logic [W-1:0] l_wdata, g_wdata;
  logic         blk_ok;
  logic [W:0]   acc_sum, set_sum;
  logic [W-1:0] inc, dec;

  bwt_ram #(.Width(W), .Depth(bwt_pkg::MaxBlocks)) u_local_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (blk_q),
    .wdata_i (l_wdata),
    .re_i    (in_acc),
    .raddr_i (block_index_i),
    .rdata_o (l_rdata)
  );

  bwt_ram #(.Width(W), .Depth(bwt_pkg::MaxBlocks)) u_global_ram (
    .clk_i   (clk_i),
    .we_i    (g_we),
    .waddr_i (blk_q),
    .wdata_i (g_wdata),
    .re_i    (in_acc),
    .raddr_i (block_index_i),
    .rdata_o (g_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bwt_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = bwt_pkg::StExec;
        end
      end
      bwt_pkg::StExec: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = bwt_pkg::StIdle;
        end
      end
      default: state_d = bwt_pkg::StIdle;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == bwt_pkg::StIdle);
    go         = (state_q == bwt_pkg::StExec) && (!out_valid_q || out_ready_i);
  end

  assign in_acc = in_valid_i && in_ready_o;

  assign loc     = lvld_q[blk_q] ? l_rdata : '0;
  assign prev    = gvld_q[blk_q] ? g_rdata : '0;
  assign blk_ok  = ({1'b0, blk_q} < num_blocks_q);
  assign acc_sum = {1'b0, loc} + {1'b0, wgt_q};
  assign inc     = wgt_q - prev;
  assign dec     = prev - wgt_q;
  assign set_sum = {1'b0, loc} + {1'b0, inc};

  always_comb begin
    total_d  = '0;
    status_d = bwt_pkg::StatOk;
    l_we     = 1'b0;
    g_we     = 1'b0;
    clr      = 1'b0;
    l_wdata  = '0;
    g_wdata  = '0;
    if (act_q == bwt_pkg::ActClear) begin
      clr = 1'b1;
      if (blk_ok) begin
        total_d = prev;
      end
    end else if (!blk_ok) begin
      status_d = bwt_pkg::StatRange;
    end else begin
      case (act_q)
        bwt_pkg::ActAccumulate: begin
          total_d = prev;
          if (acc_sum[W]) begin
            status_d = bwt_pkg::StatOverflow;
          end else begin
            l_we    = 1'b1;
            l_wdata = acc_sum[W-1:0];
          end
        end
        bwt_pkg::ActLoadTotal: begin
          g_we    = 1'b1;
          g_wdata = wgt_q;
          total_d = wgt_q;
        end
        bwt_pkg::ActSetTotal: begin
          total_d = prev;
          if (wgt_q >= prev) begin
            if (set_sum[W]) begin
              status_d = bwt_pkg::StatOverflow;
            end else begin
              l_we    = 1'b1;
              l_wdata = set_sum[W-1:0];
              g_we    = 1'b1;
              g_wdata = wgt_q;
              total_d = wgt_q;
            end
          end else if (dec > loc) begin
            status_d = bwt_pkg::StatStale;
          end else begin
            l_we    = 1'b1;
            l_wdata = loc - dec;
            g_we    = 1'b1;
            g_wdata = wgt_q;
            total_d = wgt_q;
          end
        end
        default: total_d = prev;
      endcase
    end
    l_we = l_we && go;
    g_we = g_we && go;
    clr  = clr && go;
  end

  always_comb begin
    lvld_d = lvld_q;
    gvld_d = gvld_q;
    if (clr) begin
      lvld_d = '0;
    end
    if (l_we) begin
      lvld_d[blk_q] = 1'b1;
    end
    if (g_we) begin
      gvld_d[blk_q] = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (go) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bwt_pkg::StIdle;
      num_blocks_q <= bwt_pkg::NumBlocksReset;
      lvld_q       <= '0;
      gvld_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvld_q      <= lvld_d;
      gvld_q      <= gvld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        num_blocks_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= action_i;
      blk_q <= block_index_i;
      wgt_q <= weight_i;
    end
    if (go) begin
      total_q  <= total_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign total_out_o = total_q;
  assign status_o    = status_q;

endmodule

[hw/rtl/bwt_checker.sv]
module bwt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [bwt_pkg::WeightBits-1:0] total_out_o,
  input logic [bwt_pkg::StatBits-1:0]   status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(total_out_o) && $stable(status_o))
    else $error("result item changed while stalled");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == bwt_pkg::StatRange) |-> (total_out_o == '0))
    else $error("out-of-range result carries a nonzero total");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while one is in work");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("pending result lost on accept");

endmodule

bind block_weight_table bwt_checker u_bwt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .total_out_o (total_out_o),
  .status_o    (status_o)
);
